// ----- hdl/fft8_pkg.sv -----
`timescale 1ns / 1ps

package fft8_pkg;

  // Frame geometry.
  localparam int unsigned FRAME_LEN = 8;
  localparam logic [2:0]  LAST_SLOT = 3'd7;
  localparam logic [2:0]  LAST_BIN  = 3'd7;
  localparam logic [1:0]  LAST_K    = 2'd3;

  // sqrt(0.5) scaled by 2^32, rounded; the twiddle constant is derived from it.
  localparam logic [63:0] ROOT_HALF_Q32 = 64'd3037000500;

  // Steps of the per-bin-pair schedule.
  localparam logic [2:0] STEP_DFT   = 3'd0;
  localparam logic [2:0] STEP_ISS_F = 3'd1;
  localparam logic [2:0] STEP_ISS_L = 3'd4;
  localparam logic [2:0] STEP_ACC_F = 3'd2;
  localparam logic [2:0] STEP_ACC_L = 3'd5;
  localparam logic [2:0] STEP_BFLY  = 3'd6;

  // Twiddle products, in the order the shared multiplier handles them.
  localparam logic [1:0] PROD_TR_A = 2'd0;  // real(O) term of the real part
  localparam logic [1:0] PROD_TR_B = 2'd1;  // imag(O) term of the real part
  localparam logic [1:0] PROD_TI_A = 2'd2;  // real(O) term of the imaginary part
  localparam logic [1:0] PROD_TI_B = 2'd3;  // imag(O) term of the imaginary part

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       load;
    logic       calc;
    logic       emit;
    logic       dft_en;
    logic       iss_en;
    logic       acc_en;
    logic       bfly_en;
    logic [1:0] k;
    logic [1:0] mul_sel;
    logic [1:0] acc_sel;
    logic [2:0] bin;
  } fft8_ctl_t;

endpackage

// ----- hdl/fft8_dft4.sv -----
`timescale 1ns / 1ps

module fft8_dft4 import fft8_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic signed [W-1:0]   re_i [4],
  input  logic signed [W-1:0]   im_i [4],
  input  logic        [1:0]     k_i,
  output logic signed [W+1:0]   re_o,
  output logic signed [W+1:0]   im_o
);

  logic signed [W+1:0] r0, r1, r2, r3, i0, i1, i2, i3;

  // Widen all terms so that the four-term sums cannot overflow.
  assign r0 = (W+2)'(re_i[0]);
  assign r1 = (W+2)'(re_i[1]);
  assign r2 = (W+2)'(re_i[2]);
  assign r3 = (W+2)'(re_i[3]);
  assign i0 = (W+2)'(im_i[0]);
  assign i1 = (W+2)'(im_i[1]);
  assign i2 = (W+2)'(im_i[2]);
  assign i3 = (W+2)'(im_i[3]);

  // One bin of the 4-point DFT; k picks the sign and swap pattern.
  always_comb begin
    unique case (k_i)
      2'd0: begin
        re_o = r0 + r1 + r2 + r3;
        im_o = i0 + i1 + i2 + i3;
      end
      2'd1: begin
        re_o = r0 + i1 - r2 - i3;
        im_o = i0 - r1 - i2 + r3;
      end
      2'd2: begin
        re_o = r0 - r1 + r2 - r3;
        im_o = i0 - i1 + i2 - i3;
      end
      default: begin
        re_o = r0 - i1 - r2 + i3;
        im_o = i0 + r1 - i2 - r3;
      end
    endcase
  end

endmodule

// ----- hdl/fft8_rmul.sv -----
`timescale 1ns / 1ps

module fft8_rmul import fft8_pkg::*; #(
  parameter int unsigned AW   = 18,
  parameter int unsigned CW   = 17,
  parameter int unsigned FRAC = 15,
  parameter int unsigned RW   = 19
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [CW-1:0] c_i,
  output logic signed [RW-1:0] p_o
);

  localparam int unsigned PW = AW + CW;
  localparam logic signed [PW-1:0] Half = {{(PW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] shifted;
  logic signed [RW-1:0] p_d, p_q;

  // Fixed-point product, rounded to nearest with ties toward plus infinity.
  assign prod    = a_i * c_i;
  assign biased  = prod + Half;
  assign shifted = biased >>> FRAC;
  assign p_d     = RW'(shifted);

  // The product register only loads on the cycles that issue a product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- hdl/fft8_ctrl.sv -----
`timescale 1ns / 1ps

module fft8_ctrl import fft8_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      frame_done_i,
  input  logic      out_take_i,
  output fft8_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } fft8_state_e;

  fft8_state_e state_d, state_q;
  logic [1:0]  k_d, k_q;
  logic [2:0]  step_d, step_q;
  logic [2:0]  bin_d, bin_q;

  // Load, then seven steps per bin pair, then emission of eight bins.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    step_d  = step_q;
    bin_d   = bin_q;
    unique case (state_q)
      ST_LOAD: begin
        if (frame_done_i) begin
          state_d = ST_CALC;
          k_d     = '0;
          step_d  = STEP_DFT;
        end
      end
      ST_CALC: begin
        if (step_q == STEP_BFLY) begin
          step_d = STEP_DFT;
          k_d    = k_q + 2'd1;
          if (k_q == LAST_K) begin
            state_d = ST_EMIT;
            bin_d   = '0;
          end
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_EMIT: begin
        if (out_take_i) begin
          bin_d = bin_q + 3'd1;
          if (bin_q == LAST_BIN) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      k_q     <= '0;
      step_q  <= STEP_DFT;
      bin_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      step_q  <= step_d;
      bin_q   <= bin_d;
    end
  end

  // Decode the schedule for the datapath.
  always_comb begin
    ctl_o.load    = (state_q == ST_LOAD);
    ctl_o.calc    = (state_q == ST_CALC);
    ctl_o.emit    = (state_q == ST_EMIT);
    ctl_o.dft_en  = ctl_o.calc && (step_q == STEP_DFT);
    ctl_o.iss_en  = ctl_o.calc && (step_q >= STEP_ISS_F) && (step_q <= STEP_ISS_L);
    ctl_o.acc_en  = ctl_o.calc && (step_q >= STEP_ACC_F) && (step_q <= STEP_ACC_L);
    ctl_o.bfly_en = ctl_o.calc && (step_q == STEP_BFLY);
    ctl_o.k       = k_q;
    ctl_o.mul_sel = 2'(step_q - STEP_ISS_F);
    ctl_o.acc_sel = 2'(step_q - STEP_ACC_F);
    ctl_o.bin     = bin_q;
  end

endmodule

// ----- hdl/fft_8point_complex_top.sv -----
`timescale 1ns / 1ps

// 8-point forward FFT on complex samples, radix-2 decimation in time.
//
// Input channel (s_axis): one complex sample per word, natural order, real part
// in the low half of tdata. Every eighth word completes a frame.
// Output channel (m_axis): eight words per frame in bin order 0..7; tuser
// carries the bin number and tlast marks bin 7.
//
// Timing: the first seven samples of a frame are taken one per cycle. After
// the eighth, the shared twiddle multiplier works through four bin pairs,
// each through its steps (4-point DFT bins, four products, the multiplier
// output register, one butterfly), before bin 0 appears.
// Bins then leave one per cycle while the receiver is ready. While bins are
// being emitted the first seven samples of the next frame can already be
// taken. Throughput is limited by the single multiplier and the unbuffered
// result bank.
//
// Reset empties the frame and returns to loading. When the receiver stalls,
// the current bin holds on m_axis, and once seven samples of the next frame
// are held, s_axis_tready stays low until the last bin has been taken.
module fft_8point_complex_top import fft8_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH      = 16,
  parameter int unsigned TWIDDLE_FRAC_BITS = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sample_real, sample_imag
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // result_real, result_imag
  output logic [((2*(SAMPLE_WIDTH+4)+7)/8)*8-1:0] m_axis_tdata_o,
  // bin_index
  output logic [2:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  localparam int unsigned SW  = SAMPLE_WIDTH;
  localparam int unsigned FB  = TWIDDLE_FRAC_BITS;
  localparam int unsigned EW  = SW + 2;   // 4-point DFT outputs
  localparam int unsigned CW  = FB + 2;   // twiddle coefficients
  localparam int unsigned RW  = SW + 3;   // rounded products
  localparam int unsigned OW  = SW + 4;   // twiddled terms and results

  localparam int unsigned ShiftQ = 32 - FB;
  localparam logic [63:0] RootHalfWide =
      (ROOT_HALF_Q32 + (64'd1 << (ShiftQ - 1))) >> ShiftQ;
  localparam logic signed [CW-1:0] CoefC   = CW'(RootHalfWide);
  localparam logic signed [CW-1:0] CoefOne = {2'b01, {FB{1'b0}}};
  localparam logic signed [CW-1:0] CoefNc  = -CoefC;
  localparam logic signed [CW-1:0] CoefNo  = -CoefOne;
  localparam logic signed [CW-1:0] CoefZ   = '0;

  fft8_ctl_t ctl;

  logic s_take, m_take, frame_done;
  logic [2:0] fill_d, fill_q;

  logic signed [SW-1:0] smp_re_q [FRAME_LEN];
  logic signed [SW-1:0] smp_im_q [FRAME_LEN];
  logic signed [SW-1:0] in_re, in_im;

  logic signed [SW-1:0] ev_re [4], ev_im [4], od_re [4], od_im [4];
  logic signed [EW-1:0] e_re_d, e_im_d, o_re_d, o_im_d;
  logic signed [EW-1:0] e_re_q, e_im_q, o_re_q, o_im_q;

  logic signed [EW-1:0] mul_a;
  logic signed [CW-1:0] mul_c;
  logic signed [RW-1:0] prod;
  logic signed [OW-1:0] tr_d, tr_q, ti_d, ti_q;

  logic signed [OW-1:0] res_re_q [FRAME_LEN];
  logic signed [OW-1:0] res_im_q [FRAME_LEN];
  logic signed [OW-1:0] e_re_x, e_im_x;

  // Handshakes. The eighth sample is only taken while loading.
  assign s_axis_tready_o = ctl.load || (ctl.emit && (fill_q != LAST_SLOT));
  assign s_take          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_take          = m_axis_tvalid_o && m_axis_tready_i;
  assign frame_done      = s_take && (fill_q == LAST_SLOT);

  fft8_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_done_i (frame_done),
    .out_take_i   (m_take),
    .ctl_o        (ctl)
  );

  // Fill counter; it wraps to zero when a frame is complete.
  assign fill_d = fill_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (s_take) begin
      fill_q <= fill_d;
    end
  end

  // Sample store.
  assign in_re = s_axis_tdata_i[SW-1:0];
  assign in_im = s_axis_tdata_i[2*SW-1:SW];

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      smp_re_q[fill_q] <= in_re;
      smp_im_q[fill_q] <= in_im;
    end
  end

  // Even and odd halves feed the two 4-point DFTs.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ev_re[i] = smp_re_q[2*i];
      ev_im[i] = smp_im_q[2*i];
      od_re[i] = smp_re_q[2*i+1];
      od_im[i] = smp_im_q[2*i+1];
    end
  end

  fft8_dft4 #(.W(SW)) u_dft_even (
    .re_i (ev_re),
    .im_i (ev_im),
    .k_i  (ctl.k),
    .re_o (e_re_d),
    .im_o (e_im_d)
  );

  fft8_dft4 #(.W(SW)) u_dft_odd (
    .re_i (od_re),
    .im_i (od_im),
    .k_i  (ctl.k),
    .re_o (o_re_d),
    .im_o (o_im_d)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.dft_en) begin
      e_re_q <= e_re_d;
      e_im_q <= e_im_d;
      o_re_q <= o_re_d;
      o_im_q <= o_im_d;
    end
  end

  // Operand and twiddle coefficient for the shared multiplier.
  assign mul_a = ((ctl.mul_sel == PROD_TR_A) || (ctl.mul_sel == PROD_TI_A)) ? o_re_q : o_im_q;

  always_comb begin
    unique case (ctl.k)
      2'd0: begin
        unique case (ctl.mul_sel)
          PROD_TR_A: mul_c = CoefOne;
          PROD_TR_B: mul_c = CoefZ;
          PROD_TI_A: mul_c = CoefZ;
          default:   mul_c = CoefOne;
        endcase
      end
      2'd1: begin
        unique case (ctl.mul_sel)
          PROD_TR_A: mul_c = CoefC;
          PROD_TR_B: mul_c = CoefNc;
          PROD_TI_A: mul_c = CoefNc;
          default:   mul_c = CoefC;
        endcase
      end
      2'd2: begin
        unique case (ctl.mul_sel)
          PROD_TR_A: mul_c = CoefZ;
          PROD_TR_B: mul_c = CoefNo;
          PROD_TI_A: mul_c = CoefNo;
          default:   mul_c = CoefZ;
        endcase
      end
      default: begin
        mul_c = CoefNc;
      end
    endcase
  end

  fft8_rmul #(
    .AW   (EW),
    .CW   (CW),
    .FRAC (FB),
    .RW   (RW)
  ) u_rmul (
    .clk_i (clk_i),
    .en_i  (ctl.iss_en),
    .a_i   (mul_a),
    .c_i   (mul_c),
    .p_o   (prod)
  );

  // Build the twiddled term from the four rounded products.
  always_comb begin
    tr_d = tr_q;
    ti_d = ti_q;
    unique case (ctl.acc_sel)
      PROD_TR_A: tr_d = OW'(prod);
      PROD_TR_B: tr_d = tr_q - OW'(prod);
      PROD_TI_A: ti_d = OW'(prod);
      default:   ti_d = ti_q + OW'(prod);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.acc_en) begin
      tr_q <= tr_d;
      ti_q <= ti_d;
    end
  end

  // Radix-2 butterfly writes bins k and k+4.
  assign e_re_x = OW'(e_re_q);
  assign e_im_x = OW'(e_im_q);

  always_ff @(posedge clk_i) begin
    if (ctl.bfly_en) begin
      res_re_q[{1'b0, ctl.k}] <= e_re_x + tr_q;
      res_im_q[{1'b0, ctl.k}] <= e_im_x + ti_q;
      res_re_q[{1'b1, ctl.k}] <= e_re_x - tr_q;
      res_im_q[{1'b1, ctl.k}] <= e_im_x - ti_q;
    end
  end

  // Output words come straight from the result bank.
  assign m_axis_tvalid_o = ctl.emit;
  assign m_axis_tuser_o  = ctl.bin;
  assign m_axis_tlast_o  = (ctl.bin == LAST_BIN);

  always_comb begin
    m_axis_tdata_o             = '0;
    m_axis_tdata_o[OW-1:0]     = res_re_q[ctl.bin];
    m_axis_tdata_o[2*OW-1:OW]  = res_im_q[ctl.bin];
  end

  // The eighth sample starts the computation, so the next cycle takes nothing.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (!s_axis_tready_o && !m_axis_tvalid_o))
    else $error("frame start did not enter the computation");

  // After the last bin leaves, no further word is offered.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_take && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("output continued past the last bin");

  // No samples of a new frame are held while the transform is computed.
  a_calc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.calc |-> (fill_q == 3'd0))
    else $error("samples accepted during computation");

endmodule

// ----- verif/tb_fft_8point_complex_top.sv -----
`timescale 1ns / 1ps

module tb_fft_8point_complex_top;
  import fft8_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int SAMPLE_BITS    = 16;
  localparam int RESULT_BITS    = SAMPLE_BITS + 4;
  localparam int FRAC_BITS      = 15;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES = 200_000;

  // Kinds of sample values used to fill a random frame.
  localparam int VAL_EXTREME = 0;
  localparam int VAL_SMALL   = 1;
  localparam int VAL_ZERO    = 2;
  localparam int VAL_FULL    = 3;

  // Kinds of random frames.
  localparam int FRAME_FULL    = 0;
  localparam int FRAME_EXTREME = 1;
  localparam int FRAME_SMALL   = 2;
  localparam int FRAME_MIXED   = 3;

  typedef struct {
    logic [2:0]                    bin;
    logic signed [RESULT_BITS-1:0] re;
    logic signed [RESULT_BITS-1:0] im;
    logic                          last;
  } spectrum_bin_t;

  // Keeps its own copy of the sample frame, computes the eight bins when a
  // frame completes and compares the output words against them in order.
  class spectrum_scoreboard;
    logic signed [SAMPLE_BITS-1:0] frame_re [FRAME_LEN];
    logic signed [SAMPLE_BITS-1:0] frame_im [FRAME_LEN];
    logic [2:0]                    fill_count;
    longint                        twiddle_re [4];
    longint                        twiddle_im [4];
    spectrum_bin_t                 pending_bins [$];
    int                            error_count;

    function new();
      longint one_q;
      longint root_half;
      one_q     = 64'sd1 <<< FRAC_BITS;
      root_half = longint'((ROOT_HALF_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
      // W^k = exp(-2*pi*i*k/8) in fixed point, k = 0..3.
      twiddle_re[0] = one_q;      twiddle_im[0] = 0;
      twiddle_re[1] = root_half;  twiddle_im[1] = -root_half;
      twiddle_re[2] = 0;          twiddle_im[2] = -one_q;
      twiddle_re[3] = -root_half; twiddle_im[3] = -root_half;
      fill_count  = '0;
      error_count = 0;
    endfunction

    // Product rounded to nearest with ties toward plus infinity.
    function longint round_product(longint a, longint coef);
      return (a * coef + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function void transform_frame();
      longint half_re [2][4];
      longint half_im [2][4];
      longint tw_re [4];
      longint tw_im [4];
      longint r0, r1, r2, r3, i0, i1, i2, i3;
      spectrum_bin_t b;
      // Two 4-point DFTs, even samples in half 0 and odd samples in half 1.
      for (int h = 0; h < 2; h++) begin
        r0 = frame_re[h];     i0 = frame_im[h];
        r1 = frame_re[h + 2]; i1 = frame_im[h + 2];
        r2 = frame_re[h + 4]; i2 = frame_im[h + 4];
        r3 = frame_re[h + 6]; i3 = frame_im[h + 6];
        half_re[h][0] = r0 + r1 + r2 + r3;  half_im[h][0] = i0 + i1 + i2 + i3;
        half_re[h][1] = r0 + i1 - r2 - i3;  half_im[h][1] = i0 - r1 - i2 + r3;
        half_re[h][2] = r0 - r1 + r2 - r3;  half_im[h][2] = i0 - i1 + i2 - i3;
        half_re[h][3] = r0 - i1 - r2 + i3;  half_im[h][3] = i0 + r1 - i2 - r3;
      end
      // Twiddle the odd half.
      for (int k = 0; k < 4; k++) begin
        tw_re[k] = round_product(half_re[1][k], twiddle_re[k]) -
                   round_product(half_im[1][k], twiddle_im[k]);
        tw_im[k] = round_product(half_re[1][k], twiddle_im[k]) +
                   round_product(half_im[1][k], twiddle_re[k]);
      end
      // Butterflies give bins 0..3 from the sums and 4..7 from the differences.
      for (int k = 0; k < 4; k++) begin
        b.bin  = 3'(k);
        b.re   = RESULT_BITS'(half_re[0][k] + tw_re[k]);
        b.im   = RESULT_BITS'(half_im[0][k] + tw_im[k]);
        b.last = 1'b0;
        pending_bins.push_back(b);
      end
      for (int k = 0; k < 4; k++) begin
        b.bin  = 3'(k + 4);
        b.re   = RESULT_BITS'(half_re[0][k] - tw_re[k]);
        b.im   = RESULT_BITS'(half_im[0][k] - tw_im[k]);
        b.last = (b.bin == LAST_BIN);
        pending_bins.push_back(b);
      end
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im);
      frame_re[fill_count] = re;
      frame_im[fill_count] = im;
      if (fill_count == LAST_SLOT) begin
        transform_frame();
      end
      fill_count = fill_count + 3'd1;
    endfunction

    function void check_bin(logic [2:0] bin, logic signed [RESULT_BITS-1:0] re,
                            logic signed [RESULT_BITS-1:0] im, logic last);
      spectrum_bin_t want;
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result word: bin %0d real %0d imag %0d last %0b",
                 $time, bin, re, im, last);
        error_count++;
        return;
      end
      want = pending_bins.pop_front();
      if (bin !== want.bin) begin
        $display("%0t: bin index mismatch: expected %0d actual %0d", $time, want.bin, bin);
        error_count++;
      end
      if (re !== want.re) begin
        $display("%0t: bin %0d real mismatch: expected %0d actual %0d",
                 $time, want.bin, want.re, re);
        error_count++;
      end
      if (im !== want.im) begin
        $display("%0t: bin %0d imag mismatch: expected %0d actual %0d",
                 $time, want.bin, want.im, im);
        error_count++;
      end
      if (last !== want.last) begin
        $display("%0t: bin %0d last flag mismatch: expected %0b actual %0b",
                 $time, want.bin, want.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [2*SAMPLE_BITS-1:0]  s_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [2*RESULT_BITS-1:0]  m_tdata;
  logic [2:0]                m_tuser;
  logic                      m_tlast;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off_req;

  spectrum_scoreboard spectrum_sb = new();

  fft_8point_complex_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // sample_real, sample_imag
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // result_real, result_imag
    .m_axis_tuser_o  (m_tuser),   // bin_index
    .m_axis_tlast_o  (m_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every result word taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      spectrum_sb.check_bin(m_tuser, m_tdata[RESULT_BITS-1:0],
                            m_tdata[2*RESULT_BITS-1:RESULT_BITS], m_tlast);
    end
  end

  // Offer one sample word, with a random gap first, and wait until it is taken.
  task automatic send_sample(logic [SAMPLE_BITS-1:0] re, logic [SAMPLE_BITS-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= (2*SAMPLE_BITS)'({$urandom, $urandom});
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {im, re};
    do begin
      @(posedge clk_i);
    end while (!s_tready);
    spectrum_sb.take_sample(re, im);
    @(negedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_value(int kind);
    case (kind)
      VAL_EXTREME: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      VAL_SMALL:   return SAMPLE_BITS'(int'($urandom_range(16)) - 8);
      VAL_ZERO:    return '0;
      default:     return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    int frame_kind;
    int val_kind;
    frame_kind = $urandom_range(5);
    for (int n = 0; n < FRAME_LEN; n++) begin
      case (frame_kind)
        FRAME_FULL:    val_kind = VAL_FULL;
        FRAME_EXTREME: val_kind = VAL_EXTREME;
        FRAME_SMALL:   val_kind = VAL_SMALL;
        FRAME_MIXED:   val_kind = $urandom_range(VAL_FULL);
        default:       val_kind = VAL_FULL;
      endcase
      send_sample(pick_value(val_kind), pick_value(val_kind));
    end
  endtask

  task automatic run_phase(int frames, int sender_pct, int receiver_pct, bit with_hold);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int f = 0; f < frames; f++) begin
      // Stall the receiver for a long stretch so the block fills and blocks input.
      if (with_hold && f == 3) begin
        hold_off_req = 1'b1;
      end
      send_random_frame();
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni        = 1'b0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    send_idle_pct = 26;
    recv_idle_pct = 57;
    hold_off_req  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Constant frame at the field extremes: everything lands in bin 0.
    for (int n = 0; n < FRAME_LEN; n++) begin
      send_sample(16'h8000, 16'h7fff);
    end
    // Alternating extremes: nearly all the energy goes to bin 4, a trace to bin 0.
    for (int n = 0; n < FRAME_LEN; n++) begin
      send_sample((n % 2) ? 16'h7fff : 16'h8000, (n % 2) ? 16'h8000 : 16'h7fff);
    end
    // Odd-indexed impulses exercise every twiddle and its rounding.
    for (int n = 0; n < FRAME_LEN; n++) begin
      if (n == 1) begin
        send_sample(16'h7fff, 16'h8000);
      end else if (n == 7) begin
        send_sample(16'hffff, 16'h0001);
      end else begin
        send_sample(16'h0000, 16'h0000);
      end
    end

    run_phase(15, 26, 57, 1'b0);
    run_phase(14, 57, 26, 1'b0);
    run_phase(14, 0, 0, 1'b1);
    s_tvalid <= 1'b0;

    // Drain the remaining bins, then watch for stray words.
    while (spectrum_sb.pending_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (spectrum_sb.error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/fft8_pkg.sv
hdl/fft8_dft4.sv
hdl/fft8_rmul.sv
hdl/fft8_ctrl.sv
hdl/fft_8point_complex_top.sv
verif/tb_fft_8point_complex_top.sv
